[design/tsa_pkg.sv]
// Shared types and constants for the ticket slot allocator.
package tsa_pkg;

  localparam int STRIDE_DEFAULT = 1000;
  localparam int TICKET_W       = 26;
  localparam int PAY_W          = 32;
  localparam int DOOR_W         = 16;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic {
    OP_DEPOSIT  = 1'b0,
    OP_WITHDRAW = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    op_t                      op;
    logic signed [PAY_W-1:0]  belongings;
    logic [TICKET_W-1:0]      ticket;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [TICKET_W-1:0]      issued_ticket;
    logic signed [PAY_W-1:0]  returned_belongings;
  } rsp_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    op_t                      op;
    logic                     in_range;
    logic [TICKET_W-1:0]      slot_off;
    logic [PAY_W-1:0]         payload;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/tsa_front.sv]
// Front end: door register, request acceptance and ticket-to-slot classification.
module tsa_front #(
  parameter int STRIDE = tsa_pkg::STRIDE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tsa_pkg::DOOR_W-1:0]      cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  tsa_pkg::req_t                   req,
  input  tsa_pkg::q_status_t              q_status,
  output logic                            push,
  output tsa_pkg::cmd_t                   cmd,
  output logic [tsa_pkg::TICKET_W-1:0]    base
);

  logic [tsa_pkg::TICKET_W-1:0] slot_off;

  assign cfg_ready = 1'b1;

  // The door base (door times stride, modulo the ticket width) is kept instead of the door.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= tsa_pkg::TICKET_W'(STRIDE);
    end else if (cfg_valid) begin
      base <= tsa_pkg::TICKET_W'(32'(cfg_data) * 32'(STRIDE));
    end
  end

  assign slot_off  = base - req.ticket;
  assign req_stall = q_status.full;
  assign push      = req_valid && !q_status.full;

  always_comb begin
    cmd.op       = req.op;
    cmd.in_range = slot_off < tsa_pkg::TICKET_W'(STRIDE);
    cmd.slot_off = slot_off;
    cmd.payload  = req.belongings;
  end

endmodule

[design/tsa_queue.sv]
// Short command queue between the front end and the back end.
module tsa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tsa_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output tsa_pkg::cmd_t      head,
  output tsa_pkg::q_status_t q_status
);

  localparam int DEPTH = tsa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tsa_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/tsa_back.sv]
// Back end: occupancy scan, payload store and result register.
module tsa_back #(
  parameter int STRIDE = tsa_pkg::STRIDE_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsa_pkg::cmd_t                 head,
  input  tsa_pkg::q_status_t            q_status,
  output logic                          pop,
  input  logic [tsa_pkg::TICKET_W-1:0]  base,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output tsa_pkg::rsp_t                 rsp
);

  localparam int WORDS     = (STRIDE + 63) / 64;
  localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SLOT_W    = $clog2(STRIDE);
  localparam int LAST_BITS = STRIDE - (WORDS - 1) * 64;
  localparam logic [63:0] LAST_MASK =
    (LAST_BITS == 64) ? '1 : ((64'd1 << LAST_BITS) - 64'd1);
  localparam logic [WORD_W-1:0] LAST_W = WORD_W'(WORDS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WCHK
  } state_t;

  state_t state;

  logic [63:0]              occ_mem [WORDS];
  logic [tsa_pkg::PAY_W-1:0] pay_mem [STRIDE];
  logic [WORDS-1:0]         row_valid;

  logic                     occ_re;
  logic [WORD_W-1:0]        occ_raddr;
  logic [63:0]              occ_rdata;
  logic                     occ_rvalid;
  logic                     occ_we;
  logic [WORD_W-1:0]        occ_waddr;
  logic [63:0]              occ_wdata;
  logic                     pay_re;
  logic [SLOT_W-1:0]        pay_raddr;
  logic [tsa_pkg::PAY_W-1:0] pay_rdata;
  logic                     pay_we;
  logic [SLOT_W-1:0]        pay_waddr;

  logic [WORD_W-1:0]        chk_w;
  logic [SLOT_W-1:0]        cur_slot;
  logic [tsa_pkg::PAY_W-1:0] cur_pay;

  logic [SLOT_W-1:0]        head_slot;
  logic                     start;
  logic [63:0]              word_eff;
  logic [63:0]              avail;
  logic [63:0]              lowest;
  logic [5:0]               low_idx;
  logic                     found;
  logic [SLOT_W-1:0]        found_slot;
  logic [5:0]               cur_bit;
  logic                     hit;

  assign head_slot = SLOT_W'(head.slot_off);
  assign start     = (state == S_IDLE) && !q_status.empty && !rsp_valid;
  assign pop       = start;

  // A row that was never written since reset reads as all slots free.
  assign word_eff = occ_rvalid ? occ_rdata : '0;
  assign avail    = ~word_eff & ((chk_w == LAST_W) ? LAST_MASK : '1);
  assign lowest   = avail & (~avail + 64'd1);
  assign found    = |avail;

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < 6; j++) begin
      for (int b = 0; b < 64; b++) begin
        if (((b >> j) & 1) != 0) begin
          low_idx[j] = low_idx[j] | lowest[b];
        end
      end
    end
  end

  assign found_slot = SLOT_W'({chk_w, low_idx});
  assign cur_bit    = 6'(cur_slot);
  assign hit        = word_eff[cur_bit];

  always_comb begin
    occ_re    = 1'b0;
    occ_raddr = '0;
    occ_we    = 1'b0;
    occ_waddr = chk_w;
    occ_wdata = word_eff | lowest;
    pay_re    = 1'b0;
    pay_raddr = head_slot;
    pay_we    = 1'b0;
    pay_waddr = found_slot;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (head.op == tsa_pkg::OP_DEPOSIT) begin
            occ_re = 1'b1;
          end else if (head.in_range) begin
            occ_re    = 1'b1;
            occ_raddr = WORD_W'(head_slot >> 6);
            pay_re    = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          occ_we = 1'b1;
          pay_we = 1'b1;
        end else if (chk_w != LAST_W) begin
          occ_re    = 1'b1;
          occ_raddr = chk_w + 1'b1;
        end
      end
      S_WCHK: begin
        occ_waddr = WORD_W'(cur_slot >> 6);
        occ_wdata = word_eff & ~(64'd1 << cur_bit);
        occ_we    = hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (occ_re) begin
      occ_rdata <= occ_mem[occ_raddr];
    end
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_re) begin
      pay_rdata <= pay_mem[pay_raddr];
    end
    if (pay_we) begin
      pay_mem[pay_waddr] <= cur_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      occ_rvalid <= 1'b0;
    end else begin
      if (occ_re) begin
        occ_rvalid <= row_valid[occ_raddr];
      end
      if (occ_we) begin
        row_valid[occ_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      chk_w     <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_slot <= head_slot;
            cur_pay  <= head.payload;
            chk_w    <= '0;
            if (head.op == tsa_pkg::OP_DEPOSIT) begin
              state <= S_SCAN;
            end else if (head.in_range) begin
              state <= S_WCHK;
            end else begin
              rsp_valid               <= 1'b1;
              rsp.status              <= tsa_pkg::ST_UNKNOWN;
              rsp.issued_ticket       <= '0;
              rsp.returned_belongings <= '0;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            state                   <= S_IDLE;
            rsp_valid               <= 1'b1;
            rsp.status              <= tsa_pkg::ST_OK;
            rsp.issued_ticket       <= base - tsa_pkg::TICKET_W'(found_slot);
            rsp.returned_belongings <= '0;
          end else if (chk_w == LAST_W) begin
            state                   <= S_IDLE;
            rsp_valid               <= 1'b1;
            rsp.status              <= tsa_pkg::ST_FULL;
            rsp.issued_ticket       <= '0;
            rsp.returned_belongings <= '0;
          end else begin
            chk_w <= chk_w + 1'b1;
          end
        end
        S_WCHK: begin
          state             <= S_IDLE;
          rsp_valid         <= 1'b1;
          rsp.issued_ticket <= '0;
          if (hit) begin
            rsp.status              <= tsa_pkg::ST_OK;
            rsp.returned_belongings <= pay_rdata;
          end else begin
            rsp.status              <= tsa_pkg::ST_UNKNOWN;
            rsp.returned_belongings <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A command is only carried out while the result register is empty.
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !rsp_valid)
    else $error("back end busy while a result is pending");

  // Every occupancy update flips exactly one slot.
  a_one_slot_flip: assert property (@(posedge clk) disable iff (rst)
    occ_we |-> $onehot(occ_wdata ^ word_eff))
    else $error("occupancy write changes other than one slot");

  // A full report means every row has been filled since reset.
  a_full_rows_valid: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == tsa_pkg::ST_FULL) |-> (row_valid == '1))
    else $error("full reported while a row is still untouched");

endmodule

[design/ticket_slot_allocator.sv]
// Top level of the ticket slot allocator: front end, command queue and back end.
//
// The allocator serves one door of STRIDE slots; slot k stands for ticket
// door*STRIDE-k, modulo 2^26. A deposit transaction stores its payload in the lowest free
// slot and returns that slot's ticket, or reports full; a withdraw transaction returns the
// payload of an occupied slot and frees it, or reports an unknown ticket. Each request
// transaction yields exactly one response transaction, in order. The front end accepts a
// request and queues it; the back end then takes it from the queue. A deposit scans the
// occupancy map one 64-bit word per cycle over W = ceil(STRIDE/64) words (16 for the
// default of 1000 slots) and stops early when a free slot turns up. A withdraw first reads
// the occupancy word and payload and then decides, and a ticket outside the door's range
// is answered straight from the idle state. The back end starts a new command only once
// the previous response has been taken. The occupancy map carries a valid bit per word, so
// reset clears it at once and no clearing pass is needed. The single configuration register
// holds the door base (door times stride); writes are always ready and must be issued while
// the block is idle.
module ticket_slot_allocator #(
  parameter int STRIDE = tsa_pkg::STRIDE_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tsa_pkg::DOOR_W-1:0]  cfg_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  tsa_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output tsa_pkg::rsp_t               rsp
);

  tsa_pkg::q_status_t           q_status;
  tsa_pkg::cmd_t                push_cmd;
  tsa_pkg::cmd_t                head;
  logic                         push;
  logic                         pop;
  logic [tsa_pkg::TICKET_W-1:0] base;

  // Front end: holds the door base and maps each presented ticket to a slot offset.
  tsa_front #(
    .STRIDE (STRIDE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .cmd       (push_cmd),
    .base      (base)
  );

  // The queue lets the front keep accepting while the back end scans, until the queue is full.
  tsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back end: owns the occupancy and payload memories and the response register.
  tsa_back #(
    .STRIDE (STRIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .base      (base),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
